// File: src/hsvrgb_pkg.sv
// Shared constants and stage beat types for the HSV to RGB colour converter.
// No dependencies; every other file refers to this package by scoped name.
package hsvrgb_pkg;

  localparam logic [7:0]  HUE_SECTOR1_START = 8'd86;
  localparam logic [7:0]  HUE_SECTOR2_START = 8'd171;
  localparam logic [7:0]  RAMP_SPAN         = 8'd85;
  localparam logic [15:0] RAMP_SLOPE        = 16'd771;
  localparam logic [15:0] CHANNEL_CLAMP     = 16'd32768;
  localparam logic [15:0] GRAY_STEP         = 16'd64;
  localparam logic [7:0]  VALUE_HALF        = 8'd128;
  localparam logic [15:0] WHITE_STEP        = 16'd256;

  // Clamped sector ramps, up to 32768
  typedef logic [15:0] ramp_t;
  // Saturation-blended channel, never above 32767
  typedef logic [14:0] blend_t;

  typedef struct packed {
    ramp_t      red;
    ramp_t      green;
    ramp_t      blue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } ramp_beat_t;

  typedef struct packed {
    blend_t     red;
    blend_t     green;
    blend_t     blue;
    logic [7:0] brightness;
  } blend_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_beat_t;

endpackage

// File: src/hsvrgb_hue.sv
// First pipeline stage: hue sector decode and clamped channel ramps.
// Depends on hsvrgb_pkg.
module hsvrgb_hue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              hue,
  input  logic [7:0]              saturation,
  input  logic [7:0]              brightness,
  output logic                    valid,
  input  logic                    stall,
  output hsvrgb_pkg::ramp_beat_t  beat
);

  function automatic hsvrgb_pkg::ramp_t ramp_value(input logic [6:0] k);
    logic [15:0] prod;
    prod = 16'(k) * hsvrgb_pkg::RAMP_SLOPE;
    return (prod > hsvrgb_pkg::CHANNEL_CLAMP) ? hsvrgb_pkg::CHANNEL_CLAMP : prod;
  endfunction

  logic                   advance;
  logic [6:0]             h;
  logic [6:0]             fall_k;
  hsvrgb_pkg::ramp_t      rise;
  hsvrgb_pkg::ramp_t      fall;
  hsvrgb_pkg::ramp_beat_t beat_next;

  assign advance  = !valid || !stall;
  assign in_stall = !advance;

  always_comb begin
    if (hue < hsvrgb_pkg::HUE_SECTOR1_START) begin
      h = hue[6:0];
    end else if (hue < hsvrgb_pkg::HUE_SECTOR2_START) begin
      h = 7'(hue - hsvrgb_pkg::RAMP_SPAN);
    end else begin
      h = 7'(hue - 8'(2 * hsvrgb_pkg::RAMP_SPAN));
    end
    fall_k = 7'(hsvrgb_pkg::RAMP_SPAN) - h;
    rise   = ramp_value(h);
    fall   = ramp_value(fall_k);

    beat_next.saturation = saturation;
    beat_next.brightness = brightness;
    if (hue < hsvrgb_pkg::HUE_SECTOR1_START) begin
      beat_next.red   = fall;
      beat_next.green = rise;
      beat_next.blue  = '0;
    end else if (hue < hsvrgb_pkg::HUE_SECTOR2_START) begin
      beat_next.red   = '0;
      beat_next.green = fall;
      beat_next.blue  = rise;
    end else begin
      beat_next.red   = rise;
      beat_next.green = '0;
      beat_next.blue  = fall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
    if (advance && in_valid) begin
      beat <= beat_next;
    end
  end

endmodule

// File: src/hsvrgb_sat.sv
// Second pipeline stage: blend each channel toward mid gray by saturation.
// Depends on hsvrgb_pkg.
module hsvrgb_sat (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  hsvrgb_pkg::ramp_beat_t   in_beat,
  output logic                     valid,
  input  logic                     stall,
  output hsvrgb_pkg::blend_beat_t  beat
);

  // floor(c*s/256) + (256-s)*64, bounded by 32704
  function automatic hsvrgb_pkg::blend_t sat_blend(input hsvrgb_pkg::ramp_t c,
                                                   input logic [7:0] s);
    logic [23:0] prod;
    logic [8:0]  inv;
    logic [15:0] sum;
    prod = 24'(c) * 24'(s);
    inv  = 9'd256 - 9'(s);
    sum  = prod[23:8] + 16'(inv) * hsvrgb_pkg::GRAY_STEP;
    return sum[14:0];
  endfunction

  logic                    advance;
  hsvrgb_pkg::blend_beat_t beat_next;

  assign advance  = !valid || !stall;
  assign in_stall = !advance;

  always_comb begin
    beat_next.red        = sat_blend(in_beat.red,   in_beat.saturation);
    beat_next.green      = sat_blend(in_beat.green, in_beat.saturation);
    beat_next.blue       = sat_blend(in_beat.blue,  in_beat.saturation);
    beat_next.brightness = in_beat.brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
    if (advance && in_valid) begin
      beat <= beat_next;
    end
  end

endmodule

// File: src/hsvrgb_val.sv
// Third pipeline stage: darken or whiten by brightness, drop seven bits, hold
// the result in the output register. Depends on hsvrgb_pkg.
module hsvrgb_val (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  hsvrgb_pkg::blend_beat_t  in_beat,
  output logic                     valid,
  input  logic                     stall,
  output hsvrgb_pkg::rgb_beat_t    beat
);

  // Above half: c*(256-b)/128 + (b-128)*256; otherwise c*b/128
  function automatic logic [7:0] val_blend(input hsvrgb_pkg::blend_t c,
                                           input logic [7:0] b);
    logic [7:0]  factor;
    logic [15:0] white;
    logic [22:0] prod;
    logic [15:0] sum;
    if (b > hsvrgb_pkg::VALUE_HALF) begin
      factor = 8'(9'd256 - 9'(b));
      white  = 16'(b - hsvrgb_pkg::VALUE_HALF) * hsvrgb_pkg::WHITE_STEP;
    end else begin
      factor = b;
      white  = '0;
    end
    prod = 23'(c) * 23'(factor);
    sum  = prod[22:7] + white;
    return sum[14:7];
  endfunction

  logic                  advance;
  hsvrgb_pkg::rgb_beat_t beat_next;

  assign advance  = !valid || !stall;
  assign in_stall = !advance;

  always_comb begin
    beat_next.red   = val_blend(in_beat.red,   in_beat.brightness);
    beat_next.green = val_blend(in_beat.green, in_beat.brightness);
    beat_next.blue  = val_blend(in_beat.blue,  in_beat.brightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
    if (advance && in_valid) begin
      beat <= beat_next;
    end
  end

endmodule

// File: src/hsv_to_rgb_color.sv
// Top level of the HSV to RGB colour converter: three-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_hue, hsvrgb_sat and hsvrgb_val.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_stall  | hue, saturation, brightness
//   output  | out_valid / out_stall| red, green, blue
//
// One beat per clock while out_stall is low; an accepted beat passes through
// the three registered stages (hue ramps, saturation blend, brightness blend)
// in order before it reaches the output. Each stage holds its beat only while
// the next one is full and stalled, so bubbles close up and nothing is lost or
// repeated.
// Reset clears the stage valid bits only; there is no other state.
module hsv_to_rgb_color (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic                    ramp_valid;
  logic                    ramp_stall;
  hsvrgb_pkg::ramp_beat_t  ramp_beat;
  logic                    blend_valid;
  logic                    blend_stall;
  hsvrgb_pkg::blend_beat_t blend_beat;
  hsvrgb_pkg::rgb_beat_t   rgb_beat;

  hsvrgb_hue u_hue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .valid      (ramp_valid),
    .stall      (ramp_stall),
    .beat       (ramp_beat)
  );

  hsvrgb_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ramp_valid),
    .in_stall (ramp_stall),
    .in_beat  (ramp_beat),
    .valid    (blend_valid),
    .stall    (blend_stall),
    .beat     (blend_beat)
  );

  hsvrgb_val u_val (
    .clk      (clk),
    .rst      (rst),
    .in_valid (blend_valid),
    .in_stall (blend_stall),
    .in_beat  (blend_beat),
    .valid    (out_valid),
    .stall    (out_stall),
    .beat     (rgb_beat)
  );

  assign red   = rgb_beat.red;
  assign green = rgb_beat.green;
  assign blue  = rgb_beat.blue;

`ifndef ASSERT_OFF
  // An output beat can only appear if the blend stage held one in the previous cycle
  a_out_from_blend: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(blend_valid))
    else $error("output valid rose with no beat in the blend stage");

  // A full, stalled pipeline must push back on the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && blend_valid && ramp_valid) |-> in_stall)
    else $error("input accepted while every stage is full and stalled");

  // Reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !blend_valid && !ramp_valid))
    else $error("pipeline not empty after reset");

  // A stalled blend-stage beat is held for the next cycle
  a_blend_hold: assert property (@(posedge clk) disable iff (rst)
    (blend_valid && blend_stall) |=> (blend_valid && $stable(blend_beat)))
    else $error("blend stage beat changed while stalled");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the hsv_to_rgb_color pipeline: random and directed colours,
// predicted in a scoreboard class and checked beat by beat under varied idling.
// Depends on hsvrgb_pkg and the hsv_to_rgb_color top level.
module testbench;

  localparam int unsigned RANDOM_PER_PHASE = 383;
  localparam int unsigned HELD_BEATS       = 48;
  localparam int unsigned LONG_HOLD        = 64;
  localparam int unsigned TAIL_CYCLES      = 8;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned PRINT_CAP        = 50;

  class rgb_scoreboard;
    hsvrgb_pkg::rgb_beat_t expected_rgb_q[$];
    int unsigned mismatches;
    int unsigned beats_in;
    int unsigned beats_out;

    function new();
      mismatches = 0;
      beats_in   = 0;
      beats_out  = 0;
    endfunction

    // Clamp, blend toward gray by saturation, then darken or lighten by brightness
    function automatic logic [7:0] scale_level(int unsigned level, int unsigned sat,
                                               int unsigned bri);
      int unsigned c;
      int unsigned lift;
      int unsigned top;
      c = (level > int'(hsvrgb_pkg::CHANNEL_CLAMP)) ? int'(hsvrgb_pkg::CHANNEL_CLAMP) : level;
      c = (c * sat) / 256 + (256 - sat) * int'(hsvrgb_pkg::GRAY_STEP);
      if (bri > int'(hsvrgb_pkg::VALUE_HALF)) begin
        lift = bri - int'(hsvrgb_pkg::VALUE_HALF);
        c = (c * (int'(hsvrgb_pkg::VALUE_HALF) - lift)) / int'(hsvrgb_pkg::VALUE_HALF)
            + lift * int'(hsvrgb_pkg::WHITE_STEP);
      end else begin
        c = (c * bri) / int'(hsvrgb_pkg::VALUE_HALF);
      end
      top = c >> 7;
      return top[7:0];
    endfunction

    function automatic hsvrgb_pkg::rgb_beat_t predict_rgb(logic [7:0] h, logic [7:0] s,
                                                          logic [7:0] v);
      int unsigned pos;
      int unsigned span;
      int unsigned slope;
      int unsigned ramp_r;
      int unsigned ramp_g;
      int unsigned ramp_b;
      hsvrgb_pkg::rgb_beat_t rgb;
      span  = int'(hsvrgb_pkg::RAMP_SPAN);
      slope = int'(hsvrgb_pkg::RAMP_SLOPE);
      if (h < hsvrgb_pkg::HUE_SECTOR1_START) begin
        pos    = h;
        ramp_r = (span - pos) * slope;
        ramp_g = pos * slope;
        ramp_b = 0;
      end else if (h < hsvrgb_pkg::HUE_SECTOR2_START) begin
        pos    = int'(h) - span;
        ramp_r = 0;
        ramp_g = (span - pos) * slope;
        ramp_b = pos * slope;
      end else begin
        pos    = int'(h) - 2 * span;
        ramp_r = pos * slope;
        ramp_g = 0;
        ramp_b = (span - pos) * slope;
      end
      rgb.red   = scale_level(ramp_r, s, v);
      rgb.green = scale_level(ramp_g, s, v);
      rgb.blue  = scale_level(ramp_b, s, v);
      return rgb;
    endfunction

    function void note_input(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      expected_rgb_q.push_back(predict_rgb(h, s, v));
      beats_in++;
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < PRINT_CAP)
        $display("MISMATCH beat %0d %s: got %0d, want %0d", beats_out, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsvrgb_pkg::rgb_beat_t want;
      if (expected_rgb_q.size() == 0) begin
        report_mismatch("unexpected beat, red", r, -1);
      end else begin
        want = expected_rgb_q.pop_front();
        if (r !== want.red)   report_mismatch("red", r, want.red);
        if (g !== want.green) report_mismatch("green", g, want.green);
        if (b !== want.blue)  report_mismatch("blue", b, want.blue);
      end
      beats_out++;
    endtask

    function int unsigned pending();
      return expected_rgb_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] hue = 8'd0;
  logic [7:0] saturation = 8'd0;
  logic [7:0] brightness = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  rgb_scoreboard sb = new();

  hsv_to_rgb_color u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_to_rgb_color regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold once requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(red, green, blue);
  end

  // Mostly uniform, with sector boundaries and blend extremes mixed in
  function automatic logic [7:0] pick_level();
    logic [7:0] corners [11] = '{8'd0, 8'd1, 8'd85, 8'd86, 8'd127, 8'd128, 8'd129,
                                 8'd170, 8'd171, 8'd254, 8'd255};
    if ($urandom_range(7) == 0)
      return corners[$urandom_range(10)];
    return 8'($urandom_range(255));
  endfunction

  // Offer one beat and hold it until accepted; valid stays high for a follow-on beat
  task send_beat(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(h, s, v);
  endtask

  task wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task send_random(int unsigned count);
    repeat (count) send_beat(pick_level(), pick_level(), pick_level());
  endtask

  task run_directed();
    send_beat(8'd0,   8'd255, 8'd128);
    send_beat(8'd1,   8'd255, 8'd128);
    send_beat(8'd85,  8'd255, 8'd128);
    send_beat(8'd86,  8'd255, 8'd128);
    send_beat(8'd170, 8'd255, 8'd128);
    send_beat(8'd171, 8'd255, 8'd128);
    send_beat(8'd255, 8'd255, 8'd128);
    send_beat(8'd42,  8'd0,   8'd128);
    send_beat(8'd42,  8'd255, 8'd0);
    send_beat(8'd42,  8'd255, 8'd255);
    send_beat(8'd128, 8'd128, 8'd129);
    send_beat(8'd200, 8'd1,   8'd127);
    send_beat(8'd0,   8'd0,   8'd0);
    send_beat(8'd255, 8'd255, 8'd255);
    send_beat(8'd43,  8'd200, 8'd64);
    send_beat(8'd127, 8'd254, 8'd254);
    send_beat(8'd84,  8'd128, 8'd200);
    send_beat(8'd172, 8'd64,  8'd100);
    send_beat(8'd86,  8'd0,   8'd255);
    send_beat(8'd170, 8'd255, 8'd1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_for_results();

    // Hold the output while the sender keeps pushing, so the pipe fills and backs up
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_random(HELD_BEATS);
    send_random(RANDOM_PER_PHASE - HELD_BEATS);
    wait_for_results();

    idle_pct = 71;
    stall_pct <= 0;
    send_random(RANDOM_PER_PHASE);
    wait_for_results();

    idle_pct = 0;
    stall_pct <= 71;
    send_random(RANDOM_PER_PHASE);
    wait_for_results();

    idle_pct = 19;
    stall_pct <= 19;
    send_random(RANDOM_PER_PHASE);
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("beats still owed", 0, sb.pending());

    $display("Converted %0d colours (%0d checked) across four idling phases,",
             sb.beats_in, sb.beats_out);
    $display("including a long output hold and full drains between phases.");
    if (sb.mismatches == 0) begin
      $display("hsv_to_rgb_color regression: pass");
    end else begin
      $display("hsv_to_rgb_color regression: fail");
    end
    $finish;
  end

endmodule

// File: hsv_to_rgb_color.f
src/hsvrgb_pkg.sv
src/hsvrgb_hue.sv
src/hsvrgb_sat.sv
src/hsvrgb_val.sv
src/hsv_to_rgb_color.sv
verif/testbench.sv
